/* hdl/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg - shared types and constants for the length-prefixed deframer
// Result codes, operation codes, register indexes and the result beat struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

  // width of the length field carried through the block (8 to 32)
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned TYPE_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [TYPE_W-1:0] MAX_TYPE_RST   = TYPE_W'(1000);
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = LEN_W'(8000 & ((64'd1 << LEN_W) - 1));

  // header is 4 type bytes then 4 length bytes
  localparam int unsigned HDR_CNT_W = 3;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_HDR = 2'd2,
    KIND_CLOSED  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TYPE   = 2'd0,
    REG_MAX_LENGTH = 2'd1
  } reg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data;
    logic [TYPE_W-1:0]  mtype;
    logic [LEN_W-1:0]   mlen;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

/* hdl/lpd_out_buf.sv */
// ----------------------------------------------------------------------------
// lpd_out_buf - two-entry result buffer
// Holds result beats between the parser and the output channel so the
// parser takes bytes while a head beat stalls, until both slots fill.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lpd_pkg::res_t push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lpd_pkg::res_t      head
);

  logic [1:0]    count_r, count_nxt;
  lpd_pkg::res_t head_r, head_nxt;
  lpd_pkg::res_t tail_r, tail_nxt;
  logic          pop;

  assign pop       = (count_r != 2'd0) && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign head      = head_r;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case ({push, pop})
      2'b10: begin
        count_nxt = count_r + 2'd1;
        if (count_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          tail_nxt = push_data;
        end
      end
      2'b01: begin
        count_nxt = count_r - 2'd1;
        head_nxt  = tail_r;
      end
      2'b11: begin
        // count is 1 here: the pushed beat becomes the head
        head_nxt = push_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result pushed into full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("buffer count out of range");

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (head_r == $past(head_r)))
    else $error("stalled head beat changed");

endmodule

`default_nettype wire

/* hdl/length_prefixed_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_deframer - splits a byte stream into length-prefixed messages
// Header: 32-bit LE type, 32-bit LE length, then payload. Emits one beat per
// payload byte, an empty-message beat, or a sticky cancel beat.
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+--------------------------------------
//  in_     | in  | valid / stall      | operation, data_byte
//  out_    | out | valid / stall      | result_kind, payload_byte, type, len
//  cfg_    | in  | valid / ready      | index, data (max_type, max_length)
//
//  One input beat per cycle unless stalled; a result is registered after its
//  input beat. The parse state updates in the accept cycle, so the rate is
//  set only by the two-entry output buffer: in_stall is high while it holds
//  two beats. cfg_ready is always high. Reset is synchronous (rst_n low):
//  header parse restarts, cancel clears, limits return to 1000 and 8000.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_deframer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_operation,
  input  wire logic [lpd_pkg::BYTE_W-1:0]          in_data_byte,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_result_kind,
  output logic [lpd_pkg::BYTE_W-1:0]               out_payload_byte,
  output logic [lpd_pkg::TYPE_W-1:0]               out_message_type,
  output logic [lpd_pkg::LEN_W-1:0]                out_message_length,
  output logic                                     out_last_of_message,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lpd_pkg::CFG_DAT_W-1:0]       cfg_data
);

  localparam int unsigned SHW = lpd_pkg::TYPE_W + 8;

  logic [lpd_pkg::TYPE_W-1:0]    max_type_r;
  logic [lpd_pkg::LEN_W-1:0]     max_len_r;

  logic                          in_payload_r, in_payload_nxt;
  logic [lpd_pkg::HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [lpd_pkg::TYPE_W-1:0]    type_r, type_nxt;
  logic [lpd_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic                          len_hi_r, len_hi_nxt;
  logic [lpd_pkg::LEN_W-1:0]     rem_r, rem_nxt;
  logic                          cancel_r, cancel_nxt;

  logic                          accept;
  logic                          push;
  lpd_pkg::res_t                 res;
  lpd_pkg::res_t                 head;
  logic                          buf_full;

  logic [4:0]                    shamt;
  logic [lpd_pkg::TYPE_W-1:0]    type_sh;
  logic [SHW-1:0]                len_sh;
  logic                          bad_hdr;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = buf_full;
  assign cfg_ready = 1'b1;

  // byte lane within the current header word
  assign shamt   = {hdr_cnt_r[1:0], 3'b000};
  assign type_sh = lpd_pkg::TYPE_W'(in_data_byte) << shamt;
  assign len_sh  = SHW'(in_data_byte) << shamt;

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    type_nxt       = type_r;
    len_nxt        = len_r;
    len_hi_nxt     = len_hi_r;
    rem_nxt        = rem_r;
    cancel_nxt     = cancel_r;
    push           = 1'b0;
    bad_hdr        = 1'b0;
    res.kind       = lpd_pkg::KIND_PAYLOAD;
    res.data       = '0;
    res.mtype      = type_r;
    res.mlen       = len_r;
    res.last       = 1'b0;

    if (accept && !cancel_r) begin
      if (in_operation == lpd_pkg::OP_CLOSE) begin
        if (in_payload_r || (hdr_cnt_r != '0)) begin
          push       = 1'b1;
          cancel_nxt = 1'b1;
          res.kind   = lpd_pkg::KIND_CLOSED;
          if (!in_payload_r) begin
            res.mtype = '0;
            res.mlen  = '0;
          end
        end
      end else if (in_payload_r) begin
        push     = 1'b1;
        res.data = in_data_byte;
        res.last = (rem_r <= lpd_pkg::LEN_W'(1));
        if (res.last) begin
          in_payload_nxt = 1'b0;
          rem_nxt        = '0;
        end else begin
          rem_nxt = rem_r - lpd_pkg::LEN_W'(1);
        end
      end else begin
        // header byte: first byte starts fresh words
        if (hdr_cnt_r == '0) begin
          type_nxt   = '0;
          len_nxt    = '0;
          len_hi_nxt = 1'b0;
        end
        if (!hdr_cnt_r[2]) begin
          type_nxt = type_nxt | type_sh;
        end else begin
          len_nxt    = len_nxt | len_sh[lpd_pkg::LEN_W-1:0];
          len_hi_nxt = len_hi_nxt | (|len_sh[SHW-1:lpd_pkg::LEN_W]);
        end
        hdr_cnt_nxt = hdr_cnt_r + lpd_pkg::HDR_CNT_W'(1);

        if (hdr_cnt_r == '1) begin
          bad_hdr   = (type_nxt > max_type_r) || len_hi_nxt || (len_nxt > max_len_r);
          res.mtype = type_nxt;
          if (bad_hdr) begin
            push       = 1'b1;
            cancel_nxt = 1'b1;
            res.kind   = lpd_pkg::KIND_BAD_HDR;
            res.mlen   = len_hi_nxt ? '1 : len_nxt;
          end else if (len_nxt == '0) begin
            push     = 1'b1;
            res.kind = lpd_pkg::KIND_EMPTY;
            res.mlen = '0;
            res.last = 1'b1;
          end else begin
            in_payload_nxt = 1'b1;
            rem_nxt        = len_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= '0;
      rem_r        <= '0;
      cancel_r     <= 1'b0;
      type_r       <= '0;
      len_r        <= '0;
      len_hi_r     <= 1'b0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      rem_r        <= rem_nxt;
      cancel_r     <= cancel_nxt;
      type_r       <= type_nxt;
      len_r        <= len_nxt;
      len_hi_r     <= len_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_type_r <= lpd_pkg::MAX_TYPE_RST;
      max_len_r  <= lpd_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpd_pkg::REG_MAX_TYPE:   max_type_r <= cfg_data[lpd_pkg::TYPE_W-1:0];
        lpd_pkg::REG_MAX_LENGTH: max_len_r  <= cfg_data[lpd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_result_kind     = head.kind;
  assign out_payload_byte    = head.data;
  assign out_message_type    = head.mtype;
  assign out_message_length  = head.mlen;
  assign out_last_of_message = head.last;

  a_cancel_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cancel_r |=> cancel_r)
    else $error("cancel cleared without reset");

  a_no_result_when_cancelled: assert property (@(posedge clk) disable iff (!rst_n)
    cancel_r |-> !push)
    else $error("result produced on cancelled stream");

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> ((rem_r != '0) && (hdr_cnt_r == '0)))
    else $error("payload phase with no bytes left or header partly counted");

endmodule

`default_nettype wire

/* bench/tb_length_prefixed_deframer.sv */
// ----------------------------------------------------------------------------
// tb_length_prefixed_deframer - self-checking bench for the message deframer
// Feeds framed byte streams (directed, then random messages under several
// limit settings) through bursty input beats and a stalling receiver, predicts
// every result beat in the bench and compares it field by field. The run ends
// with one sticky cancel, followed by beats the block must ignore.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_length_prefixed_deframer;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [lpd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [lpd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [lpd_pkg::LEN_W-1:0]     LEN_MAX     = '1;
  localparam int unsigned                   HOLD_CYCLES = 48;
  localparam int unsigned                   QUIET_LIMIT = 2000;
  localparam int unsigned                   SETTLE_CYCLES = 4;
  localparam int unsigned                   RANDOM_CHUNK = 250;

  typedef struct packed {
    lpd_pkg::op_t               op;
    logic [lpd_pkg::BYTE_W-1:0] data;
  } stream_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_operation = 1'b0;
  logic [lpd_pkg::BYTE_W-1:0]    in_data_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    out_result_kind;
  logic [lpd_pkg::BYTE_W-1:0]    out_payload_byte;
  logic [lpd_pkg::TYPE_W-1:0]    out_message_type;
  logic [lpd_pkg::LEN_W-1:0]     out_message_length;
  logic                          out_last_of_message;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lpd_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  length_prefixed_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_payload_byte    (out_payload_byte),
    .out_message_type    (out_message_type),
    .out_message_length  (out_message_length),
    .out_last_of_message (out_last_of_message),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #2 clk = ~clk;

  stream_beat_t  stream_q[$];
  lpd_pkg::res_t due_results[$];

  // framer state as the block should hold it
  logic [lpd_pkg::TYPE_W-1:0] lim_type = lpd_pkg::MAX_TYPE_RST;
  logic [lpd_pkg::LEN_W-1:0]  lim_len  = lpd_pkg::MAX_LENGTH_RST;
  logic                       fr_in_body = 1'b0;
  logic [2:0]                 fr_hdr_cnt = '0;
  logic [31:0]                fr_type = '0;
  logic [31:0]                fr_len = '0;
  logic [lpd_pkg::LEN_W-1:0]  fr_left = '0;
  logic                       fr_dead = 1'b0;

  int          pace = 1;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_phase = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          in_took = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cfg_writes = 0;
  int unsigned msgs_done = 0;
  int unsigned seen_kind[4] = '{0, 0, 0, 0};
  string       end_how = "nothing";

  function automatic bit deframe_step(input lpd_pkg::op_t op,
                                      input logic [lpd_pkg::BYTE_W-1:0] b,
                                      output lpd_pkg::res_t r);
    r = '0;
    if (fr_dead) return 1'b0;
    if (op == lpd_pkg::OP_CLOSE) begin
      if (!fr_in_body && fr_hdr_cnt == 0) return 1'b0;
      r.kind = lpd_pkg::KIND_CLOSED;
      // header values are reported only once the payload has begun
      if (fr_in_body) begin
        r.mtype = fr_type;
        r.mlen  = fr_len[lpd_pkg::LEN_W-1:0];
      end
      fr_dead = 1'b1;
      return 1'b1;
    end
    if (fr_in_body) begin
      r.kind  = lpd_pkg::KIND_PAYLOAD;
      r.data  = b;
      r.mtype = fr_type;
      r.mlen  = fr_len[lpd_pkg::LEN_W-1:0];
      r.last  = (fr_left <= 1);
      if (r.last) fr_in_body = 1'b0;
      else fr_left = fr_left - 1'b1;
      return 1'b1;
    end
    if (fr_hdr_cnt == 0) begin
      fr_type = '0;
      fr_len  = '0;
    end
    if (fr_hdr_cnt < 4) fr_type[8*fr_hdr_cnt +: 8] = b;
    else fr_len[8*(fr_hdr_cnt-4) +: 8] = b;
    fr_hdr_cnt = fr_hdr_cnt + 3'd1;
    if (fr_hdr_cnt != 0) return 1'b0;
    if (fr_type > lim_type || fr_len > 32'(lim_len)) begin
      r.kind  = lpd_pkg::KIND_BAD_HDR;
      r.mtype = fr_type;
      r.mlen  = (fr_len > 32'(LEN_MAX)) ? LEN_MAX : fr_len[lpd_pkg::LEN_W-1:0];
      fr_dead = 1'b1;
      return 1'b1;
    end
    if (fr_len == 0) begin
      r.kind  = lpd_pkg::KIND_EMPTY;
      r.mtype = fr_type;
      r.last  = 1'b1;
      return 1'b1;
    end
    fr_in_body = 1'b1;
    fr_left    = fr_len[lpd_pkg::LEN_W-1:0];
    return 1'b0;
  endfunction

  function automatic logic [lpd_pkg::TYPE_W-1:0] pick_type(
      input logic [lpd_pkg::TYPE_W-1:0] lim);
    int unsigned r;
    r = $urandom_range(7, 0);
    if (r == 0) return lim;
    if (r == 1) return '0;
    if (lim == '1) return $urandom;
    return $urandom_range(lim, 0);
  endfunction

  function automatic int unsigned pick_len(input logic [lpd_pkg::LEN_W-1:0] lim);
    int unsigned r, cap;
    r = $urandom_range(99, 0);
    if (lim == 0 || r < 10) return 0;
    if (r < 75) begin
      cap = (lim < 12) ? lim : 12;
      return $urandom_range(cap, 1);
    end
    if (r < 97) begin
      cap = (lim < 60) ? lim : 60;
      return $urandom_range(cap, 1);
    end
    return (lim <= 300) ? lim : $urandom_range(300, 200);
  endfunction

  task automatic push_beat(input lpd_pkg::op_t op, input logic [lpd_pkg::BYTE_W-1:0] d);
    stream_beat_t sb;
    sb.op   = op;
    sb.data = d;
    stream_q.push_back(sb);
  endtask

  task automatic add_header(input logic [31:0] mtype, input logic [31:0] mlen);
    for (int i = 0; i < 4; i++) push_beat(lpd_pkg::OP_BYTE, mtype[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_beat(lpd_pkg::OP_BYTE, mlen[8*i +: 8]);
  endtask

  // sent may be short of mlen to leave the payload unfinished
  task automatic add_message(input logic [31:0] mtype, input logic [31:0] mlen,
                             input int unsigned sent);
    add_header(mtype, mlen);
    for (int unsigned i = 0; i < sent; i++)
      push_beat(lpd_pkg::OP_BYTE, lpd_pkg::BYTE_W'($urandom));
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned fed, n;
    fed = 0;
    while (fed < target) begin
      // a close at a message boundary is noise the block ignores
      if ($urandom_range(15, 0) == 0)
        push_beat(lpd_pkg::OP_CLOSE, lpd_pkg::BYTE_W'($urandom));
      else begin
        n = pick_len(lim_len);
        add_message(pick_type(lim_type), n, n);
        fed += 8 + n;
      end
    end
  endtask

  task automatic settle();
    while (stream_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lpd_pkg::REG_MAX_TYPE:   lim_type = value;
      lpd_pkg::REG_MAX_LENGTH: lim_len  = value[lpd_pkg::LEN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // input side: take the beat and predict its result at the accepting edge
  always @(posedge clk) begin
    lpd_pkg::res_t r;
    if (rst_n && in_valid && !in_stall) begin
      in_took = 1'b1;
      if (deframe_step(lpd_pkg::op_t'(in_operation), in_data_byte, r))
        due_results.push_back(r);
      stream_q.delete(0);
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        in_valid     <= 1'b1;
        in_operation <= stream_q[0].op;
        in_data_byte <= stream_q[0].data;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(12, 1);
          gap_left   = (pace == 0) ? 0 : $urandom_range(5, 0);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold-offs on request, otherwise a per-phase stall pattern
  always @(negedge clk) begin
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      case (pace)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        2: out_stall <= ((rx_phase % 7) < 3);
        default: out_stall <= ($urandom_range(9, 0) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    lpd_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d type 0x%0h",
               out_result_kind, out_message_type);
        errors++;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
        check_field("payload_byte", 32'(want.data), 32'(out_payload_byte));
        check_field("message_type", want.mtype, out_message_type);
        check_field("message_length", 32'(want.mlen), 32'(out_message_length));
        check_field("last_of_message", 32'(want.last), 32'(out_last_of_message));
        seen_kind[want.kind]++;
        if (want.last) msgs_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned pick, k, n;
    logic [31:0] t;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle close, empty message at the type limit, one-byte message
    push_beat(lpd_pkg::OP_CLOSE, 8'h5A);
    add_message(32'd1000, 0, 0);
    add_header(32'd0, 32'd1);
    push_beat(lpd_pkg::OP_BYTE, 8'hFF);
    push_beat(lpd_pkg::OP_CLOSE, 8'h00);
    settle();

    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    write_reg(lpd_pkg::REG_MAX_TYPE, '1);
    write_reg(lpd_pkg::REG_MAX_LENGTH, 32'h0000_1FFF);
    add_header('1, 32'd1);
    push_beat(lpd_pkg::OP_BYTE, 8'h00);
    add_message('1, 300, 300);
    run_random(RANDOM_CHUNK);
    hold_asked++;
    settle();
    pace = 2;
    run_random(RANDOM_CHUNK);
    settle();

    // only empty type-0 messages pass; upper data bits must be dropped
    write_reg(lpd_pkg::REG_MAX_TYPE, '0);
    write_reg(lpd_pkg::REG_MAX_LENGTH, 32'hFFFF_E000);
    pace = 0;
    run_random(RANDOM_CHUNK);
    settle();

    write_reg(lpd_pkg::REG_MAX_TYPE, $urandom);
    write_reg(lpd_pkg::REG_MAX_LENGTH,
              ($urandom & 32'hFFFF_E000) | $urandom_range(64, 1));
    pace = 3;
    run_random(RANDOM_CHUNK);
    hold_asked++;
    settle();

    write_reg(lpd_pkg::REG_MAX_TYPE, 32'd1000);
    write_reg(lpd_pkg::REG_MAX_LENGTH, 32'd8000);
    pace = 1;
    run_random(RANDOM_CHUNK);

    // the cancel is sticky, so exactly one ends the stream
    pick = $urandom_range(4, 0);
    case (pick)
      0: begin
        end_how = "a bad header (type over limit)";
        t = $urandom_range(1, 0) ? '1 : 32'd1001 + $urandom_range(5000, 0);
        add_message(t, 4, 0);
      end
      1: begin
        end_how = "a bad header (length over limit)";
        add_message(pick_type(lim_type), $urandom_range(8191, 8001), 0);
      end
      2: begin
        end_how = "a bad header (length wider than the field)";
        add_message(pick_type(lim_type), $urandom | 32'h0000_2000, 0);
      end
      3: begin
        end_how = "a close inside a header";
        k = $urandom_range(7, 1);
        for (int unsigned i = 0; i < k; i++)
          push_beat(lpd_pkg::OP_BYTE, lpd_pkg::BYTE_W'($urandom));
        push_beat(lpd_pkg::OP_CLOSE, lpd_pkg::BYTE_W'($urandom));
      end
      default: begin
        end_how = "a close inside a payload";
        n = $urandom_range(20, 2);
        add_message(pick_type(lim_type), n, $urandom_range(n - 1, 0));
        push_beat(lpd_pkg::OP_CLOSE, lpd_pkg::BYTE_W'($urandom));
      end
    endcase
    for (int i = 0; i < 20; i++)
      push_beat(lpd_pkg::op_t'($urandom_range(1, 0)), lpd_pkg::BYTE_W'($urandom));
    settle();

    $display("Run checked %0d messages (%0d empty), %0d payload beats, %0d register writes;",
             msgs_done, seen_kind[lpd_pkg::KIND_EMPTY], seen_kind[lpd_pkg::KIND_PAYLOAD],
             cfg_writes);
    $display("stream finally cancelled by %s, later beats ignored.", end_how);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
